/* rtl/pts_pkg.sv */
package pts_pkg;

    localparam int PAGE_CNT = 1024;
    localparam int PAGE_W   = 10;
    localparam int FRAME_W  = 8;
    localparam int CMD_W    = 3;

    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_FRAME = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_VALID = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_REF   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_MOD   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIND      = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR_REF = 3'd6;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               valid;
        logic               referenced;
        logic               modified;
    } t_entry;

endpackage

/* rtl/pts_cell.sv */
module pts_cell
    import pts_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_clr_ref,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = i_entry;
        if (i_clr_ref) begin
            n_entry.referenced = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

/* rtl/page_table_store_core.sv */
// page table store: 1024 entries held in a ring of cells that rotates one place per cycle
// lookup and set commands: wait in the walk state for the page to reach the ring tail
// find by frame: one full turn of the ring; clear referenced and unknown: straight to the done state
// one command at a time; the result register lets the next command start while it waits
// synchronous active-low reset clears every entry, two_level and all control state
module page_table_store_core
    import pts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // command[2:0], page_number[12:3], frame_number[20:13], flag_value[21]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // found[0], frame_out[8:1], valid_out[9], referenced_out[10], modified_out[11], page_out[21:12]
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data     // two_level
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // field unpack
    logic [CMD_W-1:0]   w_cmd;
    logic [PAGE_W-1:0]  w_page;
    logic [FRAME_W-1:0] w_frame;
    logic               w_flag;
    assign w_cmd   = s_axis_tdata[2:0];
    assign w_page  = s_axis_tdata[12:3];
    assign w_frame = s_axis_tdata[20:13];
    assign w_flag  = s_axis_tdata[21];

    logic [1:0]         r_state, n_state;
    logic               r_two_level;
    logic [CMD_W-1:0]   r_cmd;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_frame;
    logic               r_flag;
    logic [PAGE_W-1:0]  r_pos;     // page number sitting in the tail cell
    logic [PAGE_W-1:0]  r_cnt, n_cnt;
    logic               r_hit, n_hit;
    logic [PAGE_W-1:0]  r_best, n_best;
    logic [21:0]        r_res, n_res;
    logic               r_ovalid, n_ovalid;
    logic [21:0]        r_odata, n_odata;

    logic   w_accept;
    logic   w_clr;
    logic   w_at_page;
    logic   w_match;
    t_entry w_tail;
    t_entry w_head;
    t_entry w_chain [PAGE_CNT];

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_clr         = w_accept && (w_cmd == CMD_CLEAR_REF);

    // ring of cells: the tail feeds the head, edited when the addressed page passes by
    assign w_tail    = w_chain[PAGE_CNT-1];
    assign w_at_page = (r_state == S_WALK) && (r_pos == r_page);
    assign w_match   = w_tail.valid && (w_tail.frame == r_frame);

    always_comb begin
        w_head = w_tail;
        if (w_at_page) begin
            case (r_cmd)
                CMD_SET_FRAME: w_head.frame      = r_frame;
                CMD_SET_VALID: w_head.valid      = r_flag;
                CMD_SET_REF:   w_head.referenced = r_flag;
                CMD_SET_MOD:   w_head.modified   = r_flag;
                default:       w_head = w_tail;
            endcase
        end
    end

    for (genvar k = 0; k < PAGE_CNT; k++) begin : g_ring
        pts_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clr_ref (w_clr),
            .i_entry   ((k == 0) ? w_head : w_chain[(k + PAGE_CNT - 1) % PAGE_CNT]),
            .o_entry   (w_chain[k])
        );
    end

    // command sequencer
    always_comb begin
        logic show;
        show     = w_tail.valid || !r_two_level;
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_hit    = r_hit;
        n_best   = r_best;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res = '0;
                    n_cnt = '0;
                    n_hit = 1'b0;
                    n_best = '0;
                    case (w_cmd)
                        CMD_LOOKUP, CMD_SET_FRAME, CMD_SET_VALID,
                        CMD_SET_REF, CMD_SET_MOD: n_state = S_WALK;
                        CMD_FIND:                 n_state = S_SCAN;
                        default:                  n_state = S_DONE;
                    endcase
                end
            end
            S_WALK: begin
                if (w_at_page) begin
                    if (r_cmd == CMD_LOOKUP) begin
                        n_res = {10'd0,
                                 show & w_tail.modified,
                                 show & w_tail.referenced,
                                 w_tail.valid,
                                 w_tail.valid ? w_tail.frame : {FRAME_W{1'b0}},
                                 w_tail.valid};
                    end
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                // keep the lowest matching page over one full turn
                if (w_match && (!r_hit || r_pos < r_best)) begin
                    n_hit  = 1'b1;
                    n_best = r_pos;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == {PAGE_W{1'b1}}) begin
                    n_res   = {n_best, 11'd0, n_hit};
                    n_state = S_DONE;
                end
            end
            default: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_state  = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_two_level <= 1'b0;
            r_pos       <= {PAGE_W{1'b1}};
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= r_pos + 1'b1;
            r_cnt    <= n_cnt;
            r_hit    <= n_hit;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_two_level <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= w_cmd;
            r_page  <= w_page;
            r_frame <= w_frame;
            r_flag  <= w_flag;
        end
        r_best  <= n_best;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_odata};

    // the ring turns exactly one place every cycle
    a_ring_turns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_pos == $past(r_pos) + 1'b1))
        else $error("ring position did not advance");

    // a scan starts from a zero count straight out of idle
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && w_accept && w_cmd == CMD_FIND) |=>
            (r_state == S_SCAN && r_cnt == '0))
        else $error("find scan did not start cleanly");

    // a find result without a hit carries page zero
    a_find_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cnt == {PAGE_W{1'b1}} && !n_hit) |=> (r_res == '0))
        else $error("missed find left a nonzero result");

endmodule
